/* rtl/bmptc_pkg.sv */
// ============================================================================
// bmptc_pkg
// Shared types and constants of the truecolor BMP pixel decoder.
// ============================================================================
`default_nettype none

package bmptc_pkg;

    // Image bounds and header length
    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int HEADER_BYTES = 54;
    localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CNT_W        = $clog2(MAX_DIM + 1);

    // Header byte positions
    localparam logic [5:0] POS_SIG0       = 6'd0;
    localparam logic [5:0] POS_SIG1       = 6'd1;
    localparam logic [5:0] POS_FIELD_LO   = 6'd10;
    localparam logic [5:0] POS_FIELD_HI   = 6'd33;
    localparam logic [5:0] POS_SHORT_LO   = 6'd26;
    localparam logic [5:0] POS_SHORT_HI   = 6'd29;
    localparam logic [5:0] POS_OFFSET_END = 6'd13;
    localparam logic [5:0] POS_HSIZE_END  = 6'd17;
    localparam logic [5:0] POS_WIDTH_END  = 6'd21;
    localparam logic [5:0] POS_HEIGHT_END = 6'd25;
    localparam logic [5:0] POS_PLANES_END = 6'd27;
    localparam logic [5:0] POS_BPP_END    = 6'd29;
    localparam logic [5:0] POS_COMP_END   = 6'd33;
    localparam logic [5:0] POS_HDR_LAST   = 6'(HEADER_BYTES - 1);

    localparam logic [7:0]  CHAR_B        = 8'h42;
    localparam logic [7:0]  CHAR_M        = 8'h4D;
    localparam logic [31:0] MIN_HDR_SIZE  = 32'd40;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'd255;

    // Error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE = 4'd1;
    localparam logic [3:0] ERR_HDR_SIZE  = 4'd2;
    localparam logic [3:0] ERR_PLANES    = 4'd3;
    localparam logic [3:0] ERR_COMPRESS  = 4'd4;
    localparam logic [3:0] ERR_DEPTH     = 4'd5;
    localparam logic [3:0] ERR_DIMENSION = 4'd6;
    localparam logic [3:0] ERR_TRUNCATED = 4'd7;
    localparam logic [3:0] ERR_OFFSET    = 4'd8;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd9;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_IGNORE
    } phase_t;

    // Control from the sequencer to the header unit
    typedef struct packed {
        logic       cap;
        logic       clr;
        logic [5:0] pos;
        logic [7:0] data;
    } hdr_ctl_t;

    // Decoded header as seen by the sequencer
    typedef struct packed {
        logic [3:0]       code;
        logic [31:0]      offset;
        logic [CNT_W-1:0] width;
        logic [CNT_W-1:0] rows;
        logic             bottom_up;
        logic             bpp32;
        logic [1:0]       pad;
    } hdr_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        done;
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  code;
    } res_t;

endpackage

`default_nettype wire

/* rtl/bmptc_hdr.sv */
// ============================================================================
// bmptc_hdr
// Header field capture and header validity check.
// ============================================================================
`default_nettype none

module bmptc_hdr (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bmptc_pkg::hdr_ctl_t ctl,
    output bmptc_pkg::hdr_t        hdr
);

    logic        sig_ok_reg, sig_ok_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] hsize_reg, hsize_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] planes_reg, planes_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] comp_reg, comp_next;

    logic [5:0]  pos_rel;
    logic [1:0]  k;
    logic        last;
    logic        in_field;
    logic [31:0] abs_rows;
    logic        bpp_ok;

    assign in_field = (ctl.pos >= bmptc_pkg::POS_FIELD_LO) && (ctl.pos <= bmptc_pkg::POS_FIELD_HI);
    assign pos_rel  = ctl.pos - bmptc_pkg::POS_FIELD_LO;

    always_comb begin
        if ((ctl.pos >= bmptc_pkg::POS_SHORT_LO) && (ctl.pos <= bmptc_pkg::POS_SHORT_HI)) begin
            k    = {1'b0, ctl.pos[0]};
            last = ctl.pos[0];
        end else begin
            k    = pos_rel[1:0];
            last = (pos_rel[1:0] == 2'd3);
        end
    end

    always_comb begin
        sig_ok_next = sig_ok_reg;
        asm_next    = asm_reg;
        offset_next = offset_reg;
        hsize_next  = hsize_reg;
        width_next  = width_reg;
        height_next = height_reg;
        planes_next = planes_reg;
        bpp_next    = bpp_reg;
        comp_next   = comp_reg;
        if (ctl.clr) begin
            sig_ok_next = 1'b0;
            asm_next    = '0;
            offset_next = '0;
            hsize_next  = '0;
            width_next  = '0;
            height_next = '0;
            planes_next = '0;
            bpp_next    = '0;
            comp_next   = '0;
        end else if (ctl.cap) begin
            if (ctl.pos == bmptc_pkg::POS_SIG0) begin
                sig_ok_next = (ctl.data == bmptc_pkg::CHAR_B);
            end else if (ctl.pos == bmptc_pkg::POS_SIG1) begin
                sig_ok_next = sig_ok_reg && (ctl.data == bmptc_pkg::CHAR_M);
            end else if (in_field) begin
                asm_next = ((k == 2'd0) ? 32'd0 : asm_reg) | ({24'd0, ctl.data} << {k, 3'b000});
                if (last) begin
                    case (ctl.pos)
                        bmptc_pkg::POS_OFFSET_END: offset_next = asm_next;
                        bmptc_pkg::POS_HSIZE_END:  hsize_next  = asm_next;
                        bmptc_pkg::POS_WIDTH_END:  width_next  = asm_next;
                        bmptc_pkg::POS_HEIGHT_END: height_next = asm_next;
                        bmptc_pkg::POS_PLANES_END: planes_next = asm_next[15:0];
                        bmptc_pkg::POS_BPP_END:    bpp_next    = asm_next[15:0];
                        bmptc_pkg::POS_COMP_END:   comp_next   = asm_next;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_ok_reg <= 1'b0;
            asm_reg    <= '0;
            offset_reg <= '0;
            hsize_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            planes_reg <= '0;
            bpp_reg    <= '0;
            comp_reg   <= '0;
        end else begin
            sig_ok_reg <= sig_ok_next;
            asm_reg    <= asm_next;
            offset_reg <= offset_next;
            hsize_reg  <= hsize_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            planes_reg <= planes_next;
            bpp_reg    <= bpp_next;
            comp_reg   <= comp_next;
        end
    end

    assign abs_rows = height_reg[31] ? (32'd0 - height_reg) : height_reg;
    assign bpp_ok   = (bpp_reg == bmptc_pkg::BPP_24) || (bpp_reg == bmptc_pkg::BPP_32);

    // First failing check wins
    always_comb begin
        if (!sig_ok_reg)
            hdr.code = bmptc_pkg::ERR_SIGNATURE;
        else if (hsize_reg < bmptc_pkg::MIN_HDR_SIZE)
            hdr.code = bmptc_pkg::ERR_HDR_SIZE;
        else if (offset_reg < 32'(bmptc_pkg::HEADER_BYTES))
            hdr.code = bmptc_pkg::ERR_OFFSET;
        else if (planes_reg != 16'd1)
            hdr.code = bmptc_pkg::ERR_PLANES;
        else if (comp_reg != 32'd0)
            hdr.code = bmptc_pkg::ERR_COMPRESS;
        else if (!bpp_ok)
            hdr.code = bmptc_pkg::ERR_DEPTH;
        else if (width_reg[31] || (width_reg == 32'd0) || (height_reg == 32'd0))
            hdr.code = bmptc_pkg::ERR_DIMENSION;
        else if ((width_reg > 32'(bmptc_pkg::MAX_WIDTH)) ||
                 (abs_rows > 32'(bmptc_pkg::MAX_HEIGHT)))
            hdr.code = bmptc_pkg::ERR_TOO_LARGE;
        else
            hdr.code = bmptc_pkg::ERR_NONE;
    end

    assign hdr.offset    = offset_reg;
    assign hdr.width     = width_reg[bmptc_pkg::CNT_W-1:0];
    assign hdr.rows      = abs_rows[bmptc_pkg::CNT_W-1:0];
    assign hdr.bottom_up = !height_reg[31];
    assign hdr.bpp32     = (bpp_reg == bmptc_pkg::BPP_32);
    assign hdr.pad       = (bpp_reg == bmptc_pkg::BPP_24) ? width_reg[1:0] : 2'd0;

endmodule

`default_nettype wire

/* rtl/bmptc_seq.sv */
// ============================================================================
// bmptc_seq
// Byte sequencer: header walk, offset skip, pixel assembly, row padding.
// ============================================================================
`default_nettype none

module bmptc_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [7:0]          data,
    input  wire logic                eof,
    input  wire bmptc_pkg::hdr_t     hdr,
    output bmptc_pkg::hdr_ctl_t      ctl,
    output logic                     res_valid,
    output bmptc_pkg::res_t          res
);

    localparam int CW = bmptc_pkg::CNT_W;

    bmptc_pkg::phase_t phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [1:0]    bip_reg, bip_next;
    logic [1:0]    pad_reg, pad_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;
    logic [7:0]    red_reg, red_next;

    logic [31:0]   pos_inc;
    logic          hdr_end;
    logic          pix_end;
    logic          col_wrap;
    logic          last_row;
    logic          done;
    logic [CW:0]   col_inc;
    logic [CW:0]   row_inc;
    logic [CW-1:0] y_val;
    logic [1:0]    pad_dec;

    assign pos_inc  = pos_reg + 32'd1;
    assign hdr_end  = (pos_reg == {26'd0, bmptc_pkg::POS_HDR_LAST});
    assign pix_end  = (bip_reg == (hdr.bpp32 ? 2'd3 : 2'd2));
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign col_wrap = (col_inc >= {1'b0, hdr.width});
    assign last_row = (row_inc >= {1'b0, hdr.rows});
    assign done     = col_wrap && last_row;
    assign y_val    = hdr.bottom_up ? (hdr.rows - CW'(1) - row_reg) : row_reg;
    assign pad_dec  = pad_reg - 2'd1;

    assign ctl.cap  = step && (phase_reg == PH_HEADER_C());
    assign ctl.clr  = step && eof;
    assign ctl.pos  = pos_reg[5:0];
    assign ctl.data = data;

    function automatic bmptc_pkg::phase_t PH_HEADER_C();
        return bmptc_pkg::PH_HEADER;
    endfunction

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            case (phase_reg)
                bmptc_pkg::PH_HEADER: begin
                    if (hdr_end) begin
                        if (hdr.code != bmptc_pkg::ERR_NONE)
                            phase_next = bmptc_pkg::PH_IGNORE;
                        else if (hdr.offset == pos_inc)
                            phase_next = bmptc_pkg::PH_PIXEL;
                        else
                            phase_next = bmptc_pkg::PH_SKIP;
                    end
                end
                bmptc_pkg::PH_SKIP: begin
                    if (pos_inc == hdr.offset)
                        phase_next = bmptc_pkg::PH_PIXEL;
                end
                bmptc_pkg::PH_PIXEL: begin
                    if (pix_end && col_wrap) begin
                        if (last_row)
                            phase_next = bmptc_pkg::PH_IGNORE;
                        else if (hdr.pad != 2'd0)
                            phase_next = bmptc_pkg::PH_PAD;
                    end
                end
                bmptc_pkg::PH_PAD: begin
                    if (pad_dec == 2'd0)
                        phase_next = bmptc_pkg::PH_PIXEL;
                end
                bmptc_pkg::PH_IGNORE: ;
                default: phase_next = bmptc_pkg::PH_HEADER;
            endcase
            if (eof)
                phase_next = bmptc_pkg::PH_HEADER;
        end
    end

    // Counters, held channels and result
    always_comb begin
        pos_next   = pos_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        bip_next   = bip_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (step) begin
            case (phase_reg)
                bmptc_pkg::PH_HEADER: begin
                    pos_next = pos_inc;
                    if (hdr_end) begin
                        if (hdr.code != bmptc_pkg::ERR_NONE) begin
                            res_valid = 1'b1;
                            res.kind  = bmptc_pkg::KIND_ERROR;
                            res.code  = hdr.code;
                        end else begin
                            col_next = '0;
                            row_next = '0;
                            bip_next = '0;
                            pad_next = '0;
                        end
                    end
                end
                bmptc_pkg::PH_SKIP: begin
                    pos_next = pos_inc;
                end
                bmptc_pkg::PH_PIXEL: begin
                    case (bip_reg)
                        2'd0: blue_next  = data;
                        2'd1: green_next = data;
                        2'd2: red_next   = data;
                        default: ;
                    endcase
                    if (!pix_end) begin
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        res_valid  = 1'b1;
                        res.kind   = bmptc_pkg::KIND_PIXEL;
                        res.x      = 12'(col_reg);
                        res.y      = 12'(y_val);
                        res.red    = hdr.bpp32 ? red_reg : data;
                        res.green  = green_reg;
                        res.blue   = blue_reg;
                        res.alpha  = hdr.bpp32 ? data : bmptc_pkg::ALPHA_OPAQUE;
                        res.done   = done;
                        res.width  = 13'(hdr.width);
                        res.height = 13'(hdr.rows);
                        bip_next   = 2'd0;
                        if (col_wrap) begin
                            col_next = '0;
                            if (!last_row) begin
                                row_next = row_inc[CW-1:0];
                                pad_next = hdr.pad;
                            end
                        end else begin
                            col_next = col_inc[CW-1:0];
                        end
                    end
                end
                bmptc_pkg::PH_PAD: begin
                    pad_next = pad_dec;
                end
                default: ;
            endcase
            // Truncation replaces output, except header error, last pixel, ignore phase
            if (eof && !(res_valid && (res.kind == bmptc_pkg::KIND_ERROR))
                    && !(res_valid && res.done)
                    && (phase_reg != bmptc_pkg::PH_IGNORE)) begin
                res_valid = 1'b1;
                res       = '0;
                res.kind  = bmptc_pkg::KIND_ERROR;
                res.code  = bmptc_pkg::ERR_TRUNCATED;
            end
            if (eof) begin
                pos_next = '0;
                col_next = '0;
                row_next = '0;
                bip_next = '0;
                pad_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bmptc_pkg::PH_HEADER;
            pos_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            bip_reg   <= '0;
            pad_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            bip_reg   <= bip_next;
            pad_reg   <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        blue_reg  <= blue_next;
        green_reg <= green_next;
        red_reg   <= red_next;
    end

endmodule

`default_nettype wire

/* rtl/bmp_truecolor_pixel_decoder.sv */
// ============================================================================
// bmp_truecolor_pixel_decoder
// Streaming decoder for uncompressed 24/32-bit BMP files, one pixel per group.
// ============================================================================
//
//  channel | dir | tdata                  | tuser       | tlast
//  --------+-----+------------------------+-------------+-------------------
//  s_      | in  | file byte (8 bits)     | -           | final file byte
//  m_      | out | pixel / error fields   | result kind | last image pixel
//
//  One byte is taken per clock while s_tready is high. A byte's result
//  reaches m_ after the byte has passed the input register and then the
//  result register. Stalls on m_ hold the result register and the input
//  register both, and s_tready drops only while both are full. Reset
//  (aresetn low, synchronous) empties both registers and returns the
//  decoder to the start of a file; no clearing pass is run.
//
`default_nettype none

module bmp_truecolor_pixel_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_file
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [11:0] pixel_x, [23:12] pixel_y, [31:24] red,
                                        // [39:32] green, [47:40] blue, [55:48] alpha,
                                        // [68:56] image_width, [81:69] image_height,
                                        // [85:82] error_code, [87:86] zero
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // image_done
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register
    logic            out_valid_reg, out_valid_next;
    bmptc_pkg::res_t out_res_reg;

    logic                 advance;
    logic                 seq_valid;
    bmptc_pkg::res_t      seq_res;
    bmptc_pkg::hdr_ctl_t  hdr_ctl;
    bmptc_pkg::hdr_t      hdr;

    // Advance the held byte whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = seq_valid;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && seq_valid)
            out_res_reg <= seq_res;
    end

    bmptc_hdr u_hdr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hdr_ctl),
        .hdr     (hdr)
    );

    bmptc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data      (in_byte_reg),
        .eof       (in_last_reg),
        .hdr       (hdr),
        .ctl       (hdr_ctl),
        .res_valid (seq_valid),
        .res       (seq_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.done;
    assign m_tdata  = {2'b00,
                       out_res_reg.code,
                       out_res_reg.height,
                       out_res_reg.width,
                       out_res_reg.alpha,
                       out_res_reg.blue,
                       out_res_reg.green,
                       out_res_reg.red,
                       out_res_reg.y,
                       out_res_reg.x};

endmodule

`default_nettype wire

/* verif/bmp_truecolor_pixel_decoder_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// bmp_truecolor_pixel_decoder_tb
// Self-checking bench: streams BMP files byte by byte into the decoder,
// decodes them again in a behavioral model, and compares every pixel and
// error transfer field by field under random idling on both channels.
// ============================================================================

module bmp_truecolor_pixel_decoder_tb;

    import bmptc_pkg::*;

    localparam int RANDOM_BYTES   = 1300;  // size of the random part, in file bytes
    localparam int RX_HOLD_CYCLES = 300;   // long output hold-off
    localparam int SETTLE_CYCLES  = 12;    // extra wait once no result is pending
    localparam int STUCK_LIMIT    = 2000;  // cycles without any transfer
    localparam int REPORT_LINES   = 30;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts from a known value
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;    // end_of_file
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;            // [11:0] x, [23:12] y, [31:24] red, [39:32] green,
                                     // [47:40] blue, [55:48] alpha, [68:56] width,
                                     // [81:69] height, [85:82] error_code
    logic        m_tuser;            // result_kind
    logic        m_tlast;            // image_done

    always #2 aclk = ~aclk;

    bmp_truecolor_pixel_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    res_t       decoded_pixels[$];   // pixels and error reports still to arrive
    logic [7:0] file_bytes[$];       // file being built for the next send
    int         mismatches  = 0;
    int         bytes_sent  = 0;
    bit         tx_idle_on  = 1'b1;
    bit         rx_stall_on = 1'b1;
    int         rx_hold_ask = 0;     // bumped by a test to request one long hold

    // Decoder model state
    phase_t      dec_phase;
    logic [31:0] dec_pos, dec_word, dec_offset, dec_hdr_size, dec_width, dec_height;
    logic [31:0] dec_comp;
    logic [15:0] dec_planes, dec_bpp;
    logic        dec_sig_ok;
    logic [12:0] dec_col, dec_row;
    logic [1:0]  dec_slot, dec_pad;
    logic [7:0]  px_blue, px_green, px_red;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    task automatic clear_decoder();
        dec_phase    = PH_HEADER;
        dec_pos      = '0;
        dec_word     = '0;
        dec_sig_ok   = 1'b0;
        dec_offset   = '0;
        dec_hdr_size = '0;
        dec_width    = '0;
        dec_height   = '0;
        dec_planes   = '0;
        dec_bpp      = '0;
        dec_comp     = '0;
        dec_col      = '0;
        dec_row      = '0;
        dec_slot     = '0;
        dec_pad      = '0;
        px_blue      = '0;
        px_green     = '0;
        px_red       = '0;
    endtask

    function automatic logic [31:0] row_count();
        return dec_height[31] ? (32'd0 - dec_height) : dec_height;
    endfunction

    function automatic res_t error_result(input logic [3:0] code);
        res_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.code = code;
        return r;
    endfunction

    // Assemble the little-endian header fields; planes and depth are 16-bit
    task automatic latch_header_byte(input logic [31:0] p, input logic [7:0] b);
        logic [31:0] d;
        logic [1:0]  k;
        logic        last_b;
        if (p == 32'(POS_SIG0)) begin
            dec_sig_ok = (b == CHAR_B);
        end else if (p == 32'(POS_SIG1)) begin
            dec_sig_ok = dec_sig_ok && (b == CHAR_M);
        end else if (p >= 32'(POS_FIELD_LO) && p <= 32'(POS_FIELD_HI)) begin
            if (p >= 32'(POS_SHORT_LO) && p <= 32'(POS_SHORT_HI)) begin
                d      = p - 32'(POS_SHORT_LO);
                k      = {1'b0, d[0]};
                last_b = (k == 2'd1);
            end else if (p < 32'(POS_SHORT_LO)) begin
                d      = p - 32'(POS_FIELD_LO);
                k      = d[1:0];
                last_b = (k == 2'd3);
            end else begin
                d      = p - (32'(POS_SHORT_HI) + 32'd1);
                k      = d[1:0];
                last_b = (k == 2'd3);
            end
            dec_word = ((k == 2'd0) ? 32'd0 : dec_word) | (32'(b) << (8 * k));
            if (last_b) begin
                if (p == 32'(POS_OFFSET_END))      dec_offset   = dec_word;
                else if (p == 32'(POS_HSIZE_END))  dec_hdr_size = dec_word;
                else if (p == 32'(POS_WIDTH_END))  dec_width    = dec_word;
                else if (p == 32'(POS_HEIGHT_END)) dec_height   = dec_word;
                else if (p == 32'(POS_PLANES_END)) dec_planes   = dec_word[15:0];
                else if (p == 32'(POS_BPP_END))    dec_bpp      = dec_word[15:0];
                else if (p == 32'(POS_COMP_END))   dec_comp     = dec_word;
            end
        end
    endtask

    // First failing check wins, in the block's fixed order
    function automatic logic [3:0] header_verdict();
        if (!dec_sig_ok)                                 return ERR_SIGNATURE;
        if (dec_hdr_size < MIN_HDR_SIZE)                 return ERR_HDR_SIZE;
        if (dec_offset < 32'(HEADER_BYTES))              return ERR_OFFSET;
        if (dec_planes != 16'd1)                         return ERR_PLANES;
        if (dec_comp != 32'd0)                           return ERR_COMPRESS;
        if (dec_bpp != BPP_24 && dec_bpp != BPP_32)      return ERR_DEPTH;
        if (dec_width[31] || dec_width == 32'd0 || dec_height == 32'd0)
            return ERR_DIMENSION;
        if (dec_width > 32'(MAX_WIDTH) || row_count() > 32'(MAX_HEIGHT))
            return ERR_TOO_LARGE;
        return ERR_NONE;
    endfunction

    // Advance the model by one accepted byte and queue what it produces
    task automatic decode_byte(input logic [7:0] b, input logic eof);
        res_t        r;
        logic        emit, done;
        logic [3:0]  code;
        logic [31:0] p, rows, ypos;
        logic [1:0]  slot, last_slot;
        r    = '0;
        emit = 1'b0;
        case (dec_phase)
            PH_HEADER: begin
                p = dec_pos;
                latch_header_byte(p, b);
                dec_pos = p + 32'd1;
                if (p == 32'(POS_HDR_LAST)) begin
                    code = header_verdict();
                    if (code != ERR_NONE) begin
                        r         = error_result(code);
                        emit      = 1'b1;
                        dec_phase = PH_IGNORE;
                    end else if (eof) begin
                        r    = error_result(ERR_TRUNCATED);
                        emit = 1'b1;
                    end else begin
                        dec_col   = '0;
                        dec_row   = '0;
                        dec_slot  = '0;
                        dec_pad   = '0;
                        dec_phase = (dec_offset == dec_pos) ? PH_PIXEL : PH_SKIP;
                    end
                end else if (eof) begin
                    r    = error_result(ERR_TRUNCATED);
                    emit = 1'b1;
                end
            end
            PH_SKIP: begin
                dec_pos = dec_pos + 32'd1;
                if (dec_pos == dec_offset) dec_phase = PH_PIXEL;
                if (eof) begin
                    r    = error_result(ERR_TRUNCATED);
                    emit = 1'b1;
                end
            end
            PH_PIXEL: begin
                slot      = dec_slot;
                last_slot = (dec_bpp == BPP_32) ? 2'd3 : 2'd2;
                if (slot == 2'd0)      px_blue  = b;
                else if (slot == 2'd1) px_green = b;
                else if (slot == 2'd2) px_red   = b;
                if (slot < last_slot) begin
                    dec_slot = slot + 2'd1;
                    if (eof) begin
                        r    = error_result(ERR_TRUNCATED);
                        emit = 1'b1;
                    end
                end else begin
                    rows    = row_count();
                    ypos    = dec_height[31] ? 32'(dec_row) : rows - 32'd1 - 32'(dec_row);
                    r.kind  = KIND_PIXEL;
                    r.x     = dec_col[11:0];
                    r.y     = ypos[11:0];
                    r.red   = px_red;
                    r.green = px_green;
                    r.blue  = px_blue;
                    r.alpha = (dec_bpp == BPP_32) ? b : ALPHA_OPAQUE;
                    r.width  = dec_width[12:0];
                    r.height = rows[12:0];
                    done     = 1'b0;
                    dec_slot = '0;
                    dec_col  = dec_col + 13'd1;
                    if (32'(dec_col) >= dec_width) begin
                        dec_col = '0;
                        if (32'(dec_row) + 32'd1 >= rows) begin
                            done      = 1'b1;
                            dec_phase = PH_IGNORE;
                        end else begin
                            dec_row = dec_row + 13'd1;
                            dec_pad = (dec_bpp == BPP_24) ? dec_width[1:0] : 2'd0;
                            if (dec_pad != 2'd0) dec_phase = PH_PAD;
                        end
                    end
                    r.done = done;
                    emit   = 1'b1;
                    // A short file loses the pixel it completes, unless it is the last pixel
                    if (eof && !done) r = error_result(ERR_TRUNCATED);
                end
            end
            PH_PAD: begin
                dec_pad = dec_pad - 2'd1;
                if (dec_pad == 2'd0) dec_phase = PH_PIXEL;
                if (eof) begin
                    r    = error_result(ERR_TRUNCATED);
                    emit = 1'b1;
                end
            end
            default: ;
        endcase
        if (emit) decoded_pixels.push_back(r);
        if (eof) clear_decoder();
    endtask

    // ------------------------------------------------------------------------
    // Idling: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Output side: random stalls, plus one long hold per request from a test
    int rx_holds_done = 0;
    int rx_stall_left = 0;

    always @(posedge aclk) begin
        if (rx_holds_done != rx_hold_ask) begin
            rx_holds_done++;
            rx_stall_left = RX_HOLD_CYCLES;
        end else if (rx_stall_left == 0 && rx_stall_on && $urandom_range(0, 3) == 0) begin
            rx_stall_left = idle_length();
        end
        if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checking: compare each transfer with the oldest decoded result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < REPORT_LINES)
            $display("ERROR @%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tuser;
            got.x      = m_tdata[11:0];
            got.y      = m_tdata[23:12];
            got.red    = m_tdata[31:24];
            got.green  = m_tdata[39:32];
            got.blue   = m_tdata[47:40];
            got.alpha  = m_tdata[55:48];
            got.width  = m_tdata[68:56];
            got.height = m_tdata[81:69];
            got.code   = m_tdata[85:82];
            got.done   = m_tlast;
            if (decoded_pixels.size() == 0) begin
                report_mismatch("result with nothing pending, kind", got.kind, -1);
            end else begin
                want = decoded_pixels.pop_front();
                check_field("result_kind",  got.kind,   want.kind);
                check_field("pixel_x",      got.x,      want.x);
                check_field("pixel_y",      got.y,      want.y);
                check_field("red",          got.red,    want.red);
                check_field("green",        got.green,  want.green);
                check_field("blue",         got.blue,   want.blue);
                check_field("alpha",        got.alpha,  want.alpha);
                check_field("image_done",   got.done,   want.done);
                check_field("image_width",  got.width,  want.width);
                check_field("image_height", got.height, want.height);
                check_field("error_code",   got.code,   want.code);
            end
        end
    end

    // Stop a hung run: count cycles with no transfer on either channel
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------------
    // Offer one byte; keep tvalid high into the next byte unless a gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, eof);
        bytes_sent++;
    endtask

    // Send the first n bytes of the built file (all when n <= 0), padding with
    // random bytes past its end; the last byte sent marks end of file
    task automatic send_file(input int n);
        int count;
        count = (n <= 0) ? file_bytes.size() : n;
        for (int i = 0; i < count; i++)
            send_byte((i < file_bytes.size()) ? file_bytes[i] : 8'($urandom), i == count - 1);
    endtask

    // Pause the input until every pending result has come out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (decoded_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------------
    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic build_header(input logic [7:0] s0, input logic [7:0] s1,
                                input logic [31:0] offset, input logic [31:0] hsize,
                                input logic [31:0] w, input logic [31:0] h,
                                input logic [15:0] planes, input logic [15:0] bpp,
                                input logic [31:0] comp);
        file_bytes.delete();
        file_bytes.push_back(s0);
        file_bytes.push_back(s1);
        put_le($urandom, 4);     // file size, not checked
        put_le($urandom, 4);     // reserved
        put_le(offset, 4);
        put_le(hsize, 4);
        put_le(w, 4);
        put_le(h, 4);
        put_le(32'(planes), 2);
        put_le(32'(bpp), 2);
        put_le(comp, 4);
        for (int i = 34; i < HEADER_BYTES; i++) file_bytes.push_back(8'($urandom));
    endtask

    // Gap up to the offset, then rows of random pixels; 24-bit rows padded
    task automatic append_pixels(input int offset, input int w, input int rows,
                                 input int bytes_pp);
        for (int i = HEADER_BYTES; i < offset; i++) file_bytes.push_back(8'($urandom));
        for (int r = 0; r < rows; r++) begin
            for (int i = 0; i < w * bytes_pp; i++) file_bytes.push_back(8'($urandom));
            if (bytes_pp == 3)
                for (int i = 0; i < (w & 3); i++) file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic build_image(input int w, input int h, input int bpp,
                               input int offset, input int hsize);
        build_header(CHAR_B, CHAR_M, offset, hsize, w, h, 16'd1, 16'(bpp), 32'd0);
        append_pixels(offset, w, (h < 0) ? -h : h, bpp / 8);
    endtask

    // Header alone, then a few bytes; sometimes the end of file is its last byte
    task automatic header_case(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [31:0] offset, input logic [31:0] hsize,
                               input logic [31:0] w, input logic [31:0] h,
                               input logic [15:0] planes, input logic [15:0] bpp,
                               input logic [31:0] comp);
        build_header(s0, s1, offset, hsize, w, h, planes, bpp, comp);
        send_file(HEADER_BYTES + $urandom_range(0, 4));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Well-formed images: both depths, both row orders, every padding amount,
    // pixel data right after the header or after a gap
    task automatic test_valid_images();
        build_image(1, 1, 24, 54, 40);   send_file(0);
        build_image(1, 1, 32, 54, 40);   send_file(0);
        build_image(3, 2, 24, 58, 40);   send_file(0);
        build_image(5, -3, 32, 138, 124); send_file(0);
        build_image(2, 2, 24, 54, 56);   send_file(0);
        build_image(4, 1, 24, 54, 40);   send_file(0);
        build_image(7, -2, 24, 60, 108); send_file(0);
        wait_results_drained();
    endtask

    // Each header check alone, then pairs of failures to pin down the order
    task automatic test_header_checks();
        header_case(8'h58, CHAR_M, 54, 40, 2, 2, 1, 24, 0);
        header_case(CHAR_B, 8'h58, 54, 40, 2, 2, 1, 24, 0);
        header_case(CHAR_M, CHAR_B, 54, 40, 2, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 39, 2, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 0, 0, 2, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 53, 40, 2, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 0, 40, 2, 2, 2, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 0, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 16'h0101, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 2, 24, 1);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 24, 1);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 24, 32'h8000_0000);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 16, 3);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 16, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 8, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 16'h0118, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 0, 2, 1, 1, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 0, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 32'h8000_0000, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 32'hFFFF_FFFF, 2, 1, 32, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 0, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 5000, 0, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 4097, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 32'h7FFF_FFFF, 2, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 4097, 1, 24, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, -4097, 1, 32, 0);
        header_case(CHAR_B, CHAR_M, 54, 40, 2, 32'h8000_0000, 1, 24, 0);
        // Largest legal size passes the header and is then cut short
        header_case(CHAR_B, CHAR_M, 54, 40, 4096, -4096, 1, 32, 0);
        // Failing header whose last byte also ends the file: header error wins
        build_header(CHAR_B, CHAR_M, 54, 40, 2, 2, 1, 16, 0);
        send_file(HEADER_BYTES);
        wait_results_drained();
    endtask

    // End of file in every phase: header, at the last header byte, in the gap,
    // inside a pixel, on a pixel that is not the last, in padding, and at or
    // after the very last pixel
    task automatic test_short_files();
        int cuts[$] = '{1, 2, 30, 53, 54, 58, 60, 62, 63, 70, 81, 84, 90};
        foreach (cuts[i]) begin
            build_image(3, 2, 24, 60, 40);
            send_file(cuts[i]);
        end
        build_image(2, -2, 32, 54, 40);
        send_file(61);
        wait_results_drained();
    endtask

    // Files back to back with no idling: trailing bytes after the image or
    // after an error are dropped, and each end of file restarts decoding
    task automatic test_trailing_bytes();
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        build_image(3, 1, 24, 54, 40);  send_file(file_bytes.size() + 9);
        build_image(2, -2, 32, 56, 40); send_file(0);
        build_header(CHAR_B, 8'h00, 54, 40, 2, 2, 1, 24, 0);
        send_file(80);
        file_bytes.delete();
        for (int i = 0; i < 20; i++) file_bytes.push_back(8'($urandom));
        send_file(0);
        build_image(1, 3, 24, 54, 40);  send_file(0);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        wait_results_drained();
    endtask

    // Widest and tallest images, for the top column and row numbers
    task automatic test_size_limits();
        build_image(4096, 1, 32, 54, 40);
        send_file(0);
        build_image(1, 4096, 24, 54, 40);
        send_file(0);
        wait_results_drained();
    endtask

    // Hold the output off for a long stretch while bytes keep coming, so the
    // block fills and drops s_tready; then pause until it has drained
    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        rx_hold_ask++;
        build_image(8, 4, 32, 54, 40);
        send_file(0);
        wait_results_drained();
        build_image(5, -2, 24, 57, 40);
        send_file(0);
        tx_idle_on = 1'b1;
        wait_results_drained();
    endtask

    // Mostly well-formed files with random content, some broken headers,
    // cut files and plain noise
    task automatic test_random_files();
        int first, w, h, bpp, off, hs, pick, n;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            w    = $urandom_range(1, 6);
            h    = $urandom_range(1, 4);
            if ($urandom_range(0, 1)) h = -h;
            bpp  = $urandom_range(0, 1) ? 32 : 24;
            off  = ($urandom_range(0, 1)) ? 54 : 54 + $urandom_range(1, 6);
            hs   = $urandom_range(40, 140);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                build_image(w, h, bpp, off, hs);
                n = file_bytes.size();
                if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n - 1);
                else if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 6);
                send_file(n);
            end else if (pick < 85) begin
                case ($urandom_range(0, 6))
                    0: header_case(CHAR_B, 8'($urandom), off, hs, w, h, 1, bpp, 0);
                    1: header_case(CHAR_B, CHAR_M, off, $urandom_range(0, 39), w, h, 1, bpp, 0);
                    2: header_case(CHAR_B, CHAR_M, $urandom_range(0, 53), hs, w, h, 1, bpp, 0);
                    3: header_case(CHAR_B, CHAR_M, off, hs, w, h, 16'($urandom), bpp, 0);
                    4: header_case(CHAR_B, CHAR_M, off, hs, w, h, 1, bpp, $urandom);
                    5: header_case(CHAR_B, CHAR_M, off, hs, w, h, 1, 16'($urandom), 0);
                    default: header_case(CHAR_B, CHAR_M, off, hs, $urandom, $urandom,
                                         1, bpp, 0);
                endcase
            end else begin
                file_bytes.delete();
                if ($urandom_range(0, 1)) begin
                    file_bytes.push_back(CHAR_B);
                    file_bytes.push_back(CHAR_M);
                end
                n = $urandom_range(1, 70);
                for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
                send_file(0);
            end
            if ($urandom_range(0, 4) == 0) wait_results_drained();
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence: one reset, the tests in turn, then the verdict
    // ------------------------------------------------------------------------
    initial begin
        clear_decoder();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_valid_images();
        test_header_checks();
        test_short_files();
        test_trailing_bytes();
        test_size_limits();
        test_output_stall();
        test_random_files();
        wait_results_drained();
        if (mismatches == 0 && decoded_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
